// ===== rtl/core/bgps_pkg.sv =====
package bgps_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
    localparam int FORCE_W         = 20;
    localparam int THR_W           = 19;
    localparam int CFG_DATA_W      = 19;
    localparam int CFG_IDX_W       = 2;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_STAND    = 2'd0,
        MODE_WALK     = 2'd1,
        MODE_TO_STAND = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_PHASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_FORCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_FORCE   = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_INC_RST     = 17'd655;
    localparam logic [PHASE_W-1:0] SWITCH_PHASE_RST  = 17'd39322;
    localparam logic [THR_W-1:0]   CONTACT_FORCE_RST = 19'd1600;
    localparam logic [THR_W-1:0]   TOUCH_FORCE_RST   = 19'd3200;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_inc;
        logic [PHASE_W-1:0] switch_phase;
        logic [THR_W-1:0]   contact_force;
        logic [THR_W-1:0]   touch_force;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic               stance_is_left;
        logic [PHASE_W-1:0] gait_phase;
        logic               touchdown_seen;
        logic               capture;
    } result_t;

endpackage

// ===== rtl/core/bgps_cfg.sv =====
module bgps_cfg
    import bgps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc     <= PHASE_INC_RST;
            cfg_reg.switch_phase  <= SWITCH_PHASE_RST;
            cfg_reg.contact_force <= CONTACT_FORCE_RST;
            cfg_reg.touch_force   <= TOUCH_FORCE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PHASE_INC:     cfg_reg.phase_inc     <= cfg_wdata[PHASE_W-1:0];
                REG_SWITCH_PHASE:  cfg_reg.switch_phase  <= cfg_wdata[PHASE_W-1:0];
                REG_CONTACT_FORCE: cfg_reg.contact_force <= cfg_wdata[THR_W-1:0];
                REG_TOUCH_FORCE:   cfg_reg.touch_force   <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bgps_step.sv =====
module bgps_step
    import bgps_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  cfg_t                      cfg,
    input  logic [1:0]                req_mode,
    input  logic signed [FORCE_W-1:0] left_force,
    input  logic signed [FORCE_W-1:0] right_force,
    output result_t                   result
);

    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] phase_acc_next;
    logic               left_reg;
    logic               left_next;
    logic               init_reg;
    logic               touch_reg;
    logic               touch_next;

    mode_t              mode;
    logic               standing;
    logic               walking;
    logic               left_pre;
    logic               init_pre;
    logic               touch_pre;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W:0]   phase_pre;
    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] base;
    logic signed [FORCE_W-1:0] swing_force;
    logic               contact_hit;
    logic               touch_hit;
    logic               do_switch;

    always_comb begin
        if (req_mode == MODE_WALK) begin
            mode = MODE_WALK;
        end else if (req_mode == MODE_TO_STAND && !touch_reg) begin
            mode = MODE_TO_STAND;
        end else begin
            mode = MODE_STAND;
        end
        standing  = (mode == MODE_STAND);
        walking   = (mode == MODE_WALK);
        base      = standing ? '0 : phase_acc_reg;
        step      = standing ? '0 : cfg.phase_inc;
        left_pre  = standing ? 1'b0 : left_reg;
        init_pre  = standing ? 1'b0 : init_reg;
        touch_pre = walking ? 1'b0 : touch_reg;
        phase_sum = {1'b0, base} + {1'b0, step};

        // Thresholds are unsigned, so a negative force never reaches one.
        swing_force = left_pre ? right_force : left_force;
        contact_hit = !swing_force[FORCE_W-1] &&
                      ({1'b0, swing_force[FORCE_W-2:0]} >= {1'b0, cfg.contact_force});
        touch_hit   = !swing_force[FORCE_W-1] &&
                      ({1'b0, swing_force[FORCE_W-2:0]} >= {1'b0, cfg.touch_force});

        // The phase threshold is checked before saturation at one.
        do_switch = walking && contact_hit && (phase_sum >= {1'b0, cfg.switch_phase});
        left_next = do_switch ? !left_pre : left_pre;
        phase_pre = do_switch ? '0 : phase_sum;
        phase_acc_next = (phase_pre >= {1'b0, PHASE_ONE}) ? PHASE_ONE
                                                          : phase_pre[PHASE_W-1:0];
        touch_next = (!walking && touch_hit) ? 1'b1 : touch_pre;

        result.mode           = mode;
        result.stance_is_left = left_next;
        result.gait_phase     = phase_acc_next;
        result.touchdown_seen = touch_next;
        result.capture        = !init_pre || do_switch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            left_reg      <= 1'b0;
            init_reg      <= 1'b0;
            touch_reg     <= 1'b0;
        end else if (step_en) begin
            phase_acc_reg <= phase_acc_next;
            left_reg      <= left_next;
            init_reg      <= 1'b1;
            touch_reg     <= touch_next;
        end
    end

    a_phase_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_acc_reg <= PHASE_ONE)
        else $error("phase accumulator above one");

    a_stand_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.mode == MODE_STAND) |->
            (result.capture && !result.stance_is_left && result.gait_phase == '0))
        else $error("stand tick did not reset stance and phase");

    a_walk_clears_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.mode == MODE_WALK) |=> !touch_reg)
        else $error("walk tick left touchdown latched");

    a_to_stand_needs_no_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.mode == MODE_TO_STAND) |-> !touch_reg)
        else $error("walk-to-stand kept after touchdown");

endmodule

// ===== rtl/core/biped_gait_phase_scheduler_top.sv =====
// Biped gait phase scheduler.
// The input channel (s_valid/s_ready) carries one control tick: the requested
// mode and both feet's signed vertical forces. The result channel
// (m_valid/m_ready) returns exactly one result per tick: resulting mode,
// stance leg, gait phase, touchdown latch and the start position capture flag.
// The configuration port writes one of four registers per clock; the user must
// write it only while the block is idle, which the block does not enforce;
// there is no read-back. A tick is held in an input register, then evaluated
// against the gait state and written to the output register. Throughput is one
// tick per cycle while m_ready stays high; the gait state updates in the same
// cycle that the tick is evaluated.
// Reset (aresetn low, synchronous) empties both registers, loads the default
// register values and clears the phase, stance, initialization and touchdown
// state. When the receiver holds m_ready low, the output register keeps its
// result, the input register fills, and s_ready then drops until the result
// is taken.
module biped_gait_phase_scheduler_top
    import bgps_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_requested_mode,
    input  logic signed [FORCE_W-1:0] s_left_vertical_force,
    input  logic signed [FORCE_W-1:0] s_right_vertical_force,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_resulting_mode,
    output logic                      m_stance_is_left,
    output logic [PHASE_W-1:0]        m_gait_phase,
    output logic                      m_touchdown_seen,
    output logic                      m_capture_start_positions
);

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_valid_reg;
    logic [1:0]                in_mode_reg;
    logic signed [FORCE_W-1:0] in_left_reg;
    logic signed [FORCE_W-1:0] in_right_reg;
    logic    advance;

    bgps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A held tick moves to the output register whenever that register is
    // empty or its result is being transferred out.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bgps_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .cfg         (cfg),
        .req_mode    (in_mode_reg),
        .left_force  (in_left_reg),
        .right_force (in_right_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_mode_reg  <= s_requested_mode;
            in_left_reg  <= s_left_vertical_force;
            in_right_reg <= s_right_vertical_force;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid                   = out_valid_reg;
    assign m_resulting_mode          = out_reg.mode;
    assign m_stance_is_left          = out_reg.stance_is_left;
    assign m_gait_phase              = out_reg.gait_phase;
    assign m_touchdown_seen          = out_reg.touchdown_seen;
    assign m_capture_start_positions = out_reg.capture;

endmodule
